@@ hw/rtl/tdi_pkg.sv @@
// Shared widths, register indexes and types for the temperature to duration interpolator.
package tdi_pkg;

    localparam int TEMP_W              = 16;   // signed sixteenths of a degree C
    localparam int SECS_W              = 16;   // unsigned seconds
    localparam int BP_W                = 32;   // packed breakpoint register
    localparam int COUNT_W             = 3;    // point_count register
    localparam int CFG_IDX_W           = 3;    // register index
    localparam int DEFAULT_MAX_POINTS  = 7;

    // register indexes
    localparam int REG_POINT_COUNT     = 0;
    localparam int REG_BREAKPOINT_0    = 1;

    // datapath
    localparam int DIFF_W              = TEMP_W + 1;      // difference of two 16 bit values
    localparam int MAG_W               = TEMP_W;          // magnitude of such a difference
    localparam int NUM_W               = 2 * MAG_W;       // product magnitude
    localparam int DIV_BITS_PER_STAGE  = 4;
    localparam int DIV_STAGES          = NUM_W / DIV_BITS_PER_STAGE;
    localparam int SUM_W               = NUM_W + 2;

    // select, difference, multiply, divider stages, output
    localparam int PIPE_LATENCY        = 3 + DIV_STAGES + 1;

    // side data carried alongside the divider
    typedef struct packed {
        logic              neg;
        logic [SECS_W-1:0] base;
    } side_t;

endpackage

@@ hw/rtl/temperature_to_duration_interpolator.sv @@
// Top level: piecewise linear map from temperature to duration, fully pipelined.
//
//  Channel   Signals                              Transfer
//  --------  -----------------------------------  ------------------------------------
//  input     start, busy, temperature_in          edge with start high and busy low
//  result    done, duration_seconds               edge ending the cycle done is high
//  config    cfg_we, cfg_index, cfg_data          edge with cfg_we high
//
// One temperature may enter every cycle; busy is never raised.
// Each result transfer follows its input transfer through the registered stages: breakpoint
// select, differences, one 16x16 multiply, eight divider stages of four quotient
// bits each, then sign, add and saturate.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the config registers.
// The receiver cannot hold results off, so nothing in the pipe ever stalls.
module temperature_to_duration_interpolator #(
    parameter int MAX_POINTS = tdi_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input transfer
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tdi_pkg::TEMP_W-1:0] temperature_in,
    // result transfer
    output logic                              done,
    output logic        [tdi_pkg::SECS_W-1:0] duration_seconds,
    // configuration writes
    input  logic                              cfg_we,
    input  logic        [tdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [tdi_pkg::BP_W-1:0]   cfg_data
);

    localparam int TEMP_W  = tdi_pkg::TEMP_W;
    localparam int SECS_W  = tdi_pkg::SECS_W;
    localparam int COUNT_W = tdi_pkg::COUNT_W;
    localparam int IDX_W   = tdi_pkg::CFG_IDX_W;
    localparam int DIFF_W  = tdi_pkg::DIFF_W;
    localparam int MAG_W   = tdi_pkg::MAG_W;
    localparam int NUM_W   = tdi_pkg::NUM_W;
    localparam int SUM_W   = tdi_pkg::SUM_W;

    // ------------------------------------------------------------------
    // Configuration registers. Breakpoints at index MAX_POINTS and up are
    // never read, so they are not stored.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]      point_count_reg;
    logic [tdi_pkg::BP_W-1:0] bp_reg [MAX_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                bp_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == IDX_W'(tdi_pkg::REG_POINT_COUNT))
            begin
                point_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (cfg_index == IDX_W'(tdi_pkg::REG_BREAKPOINT_0 + i))
                begin
                    bp_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Pipeline never refuses an item.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: find the bracketing breakpoints.
    // lower = highest index at or below t, upper = lowest index at or above t.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]      count_eff;
    logic                    have_lo, have_hi;
    logic signed [TEMP_W-1:0] t_lo, t_hi;
    logic [SECS_W-1:0]       s_lo, s_hi;

    always_comb
    begin
        count_eff = (point_count_reg > COUNT_W'(MAX_POINTS)) ?
                    COUNT_W'(MAX_POINTS) : point_count_reg;
        have_lo = 1'b0;
        have_hi = 1'b0;
        t_lo    = '0;
        t_hi    = '0;
        s_lo    = '0;
        s_hi    = '0;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if ((COUNT_W'(i) < count_eff) &&
                ($signed(bp_reg[i][31:16]) <= temperature_in))
            begin
                have_lo = 1'b1;
                t_lo    = $signed(bp_reg[i][31:16]);
                s_lo    = bp_reg[i][SECS_W-1:0];
            end
        end
        for (int i = MAX_POINTS - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < count_eff) &&
                ($signed(bp_reg[i][31:16]) >= temperature_in))
            begin
                have_hi = 1'b1;
                t_hi    = $signed(bp_reg[i][31:16]);
                s_hi    = bp_reg[i][SECS_W-1:0];
            end
        end
    end

    logic                     s1_vld_reg;
    logic                     s1_have_lo_reg, s1_have_hi_reg;
    logic signed [TEMP_W-1:0] s1_t_reg, s1_t_lo_reg, s1_t_hi_reg;
    logic [SECS_W-1:0]        s1_s_lo_reg, s1_s_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_have_lo_reg <= have_lo;
        s1_have_hi_reg <= have_hi;
        s1_t_reg       <= temperature_in;
        s1_t_lo_reg    <= t_lo;
        s1_t_hi_reg    <= t_hi;
        s1_s_lo_reg    <= s_lo;
        s1_s_hi_reg    <= s_hi;
    end

    // ------------------------------------------------------------------
    // Stage 2: differences, magnitudes and the sign of the quotient.
    // No interpolation (one side missing, or zero span) gives a zero
    // numerator over one, so only the base value survives.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dt, span_s, span_t;
    logic [DIFF_W-1:0]        dt_abs, span_s_abs, span_t_abs;
    logic                     interp;
    tdi_pkg::side_t           side_next;

    always_comb
    begin
        dt     = {s1_t_reg[TEMP_W-1], s1_t_reg} - {s1_t_lo_reg[TEMP_W-1], s1_t_lo_reg};
        span_t = {s1_t_hi_reg[TEMP_W-1], s1_t_hi_reg}
                 - {s1_t_lo_reg[TEMP_W-1], s1_t_lo_reg};
        span_s = {1'b0, s1_s_hi_reg} - {1'b0, s1_s_lo_reg};
        dt_abs     = dt[DIFF_W-1]     ? -dt     : dt;
        span_s_abs = span_s[DIFF_W-1] ? -span_s : span_s;
        span_t_abs = span_t[DIFF_W-1] ? -span_t : span_t;
        interp = s1_have_lo_reg && s1_have_hi_reg && (span_t != '0);

        side_next.neg = dt[DIFF_W-1] ^ span_s[DIFF_W-1] ^ span_t[DIFF_W-1];
        if (s1_have_lo_reg)
        begin
            side_next.base = s1_s_lo_reg;
        end
        else if (s1_have_hi_reg)
        begin
            side_next.base = s1_s_hi_reg;
        end
        else
        begin
            side_next.base = '0;
        end
    end

    logic                     s2_vld_reg;
    logic [MAG_W-1:0]         s2_a_reg, s2_b_reg, s2_den_reg;
    tdi_pkg::side_t           s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg    <= interp ? dt_abs[MAG_W-1:0] : '0;
        s2_b_reg    <= span_s_abs[MAG_W-1:0];
        s2_den_reg  <= interp ? span_t_abs[MAG_W-1:0] : MAG_W'(1);
        s2_side_reg <= side_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: 16x16 unsigned multiply of the magnitudes.
    // ------------------------------------------------------------------
    logic                     s3_vld_reg;
    logic [NUM_W-1:0]         s3_prod_reg;
    logic [MAG_W-1:0]         s3_den_reg;
    tdi_pkg::side_t           s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_prod_reg <= NUM_W'(s2_a_reg) * NUM_W'(s2_b_reg);
        s3_den_reg  <= s2_den_reg;
        s3_side_reg <= s2_side_reg;
    end

    // ------------------------------------------------------------------
    // Divider: magnitude quotient, truncation toward zero once the sign
    // is put back.
    // ------------------------------------------------------------------
    logic             div_vld;
    logic [NUM_W-1:0] div_quot;
    tdi_pkg::side_t   div_side;

    tdi_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .in_num    (s3_prod_reg),
        .in_den    (s3_den_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_vld),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Output stage: apply sign, add base seconds, saturate to 0..65535.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] sum;
    logic [SECS_W-1:0]       sat;

    always_comb
    begin
        q_signed = div_side.neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
        sum      = q_signed + $signed({{(SUM_W-SECS_W){1'b0}}, div_side.base});
        if (sum[SUM_W-1])
        begin
            sat = '0;
        end
        else if (|sum[SUM_W-2:SECS_W])
        begin
            sat = '1;
        end
        else
        begin
            sat = sum[SECS_W-1:0];
        end
    end

    logic              done_reg;
    logic [SECS_W-1:0] duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        duration_reg <= sat;
    end

    assign done             = done_reg;
    assign duration_seconds = duration_reg;

endmodule

@@ hw/rtl/tdi_div_pipe.sv @@
// Pipelined unsigned restoring divider, four quotient bits per stage.
module tdi_div_pipe (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [tdi_pkg::NUM_W-1:0] in_num,
    input  logic [tdi_pkg::MAG_W-1:0] in_den,
    input  tdi_pkg::side_t            in_side,
    output logic                      out_valid,
    output logic [tdi_pkg::NUM_W-1:0] out_quot,
    output tdi_pkg::side_t            out_side
);

    localparam int NS    = tdi_pkg::DIV_STAGES;
    localparam int BPS   = tdi_pkg::DIV_BITS_PER_STAGE;
    localparam int NUM_W = tdi_pkg::NUM_W;
    localparam int DEN_W = tdi_pkg::MAG_W;

    logic [NS-1:0]    vld_reg;
    logic [NUM_W-1:0] num_reg  [NS];   // remaining dividend bits, quotient shifts in low
    logic [DEN_W-1:0] rem_reg  [NS];
    logic [DEN_W-1:0] den_reg  [NS];
    tdi_pkg::side_t   side_reg [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic             vld_src;
            logic [NUM_W-1:0] num_src;
            logic [DEN_W-1:0] rem_src;
            logic [DEN_W-1:0] den_src;
            tdi_pkg::side_t   side_src;
            logic [NUM_W-1:0] num_next;
            logic [DEN_W-1:0] rem_next;
            logic [DEN_W:0]   trial;

            if (s == 0)
            begin : g_first
                assign vld_src  = in_valid;
                assign num_src  = in_num;
                assign rem_src  = '0;
                assign den_src  = in_den;
                assign side_src = in_side;
            end
            else
            begin : g_rest
                assign vld_src  = vld_reg[s-1];
                assign num_src  = num_reg[s-1];
                assign rem_src  = rem_reg[s-1];
                assign den_src  = den_reg[s-1];
                assign side_src = side_reg[s-1];
            end

            always_comb
            begin
                num_next = num_src;
                rem_next = rem_src;
                trial    = '0;
                for (int k = 0; k < BPS; k++)
                begin
                    trial    = {rem_next, num_next[NUM_W-1]};
                    num_next = {num_next[NUM_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_src})
                    begin
                        trial       = trial - {1'b0, den_src};
                        num_next[0] = 1'b1;
                    end
                    rem_next = trial[DEN_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else
                begin
                    vld_reg[s] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                num_reg[s]  <= num_next;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_src;
                side_reg[s] <= side_src;
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_quot  = num_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ hw/rtl/tdi_checker.sv @@
// Port-level checks on the interpolator, bound to the top level.
module tdi_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LAT = tdi_pkg::PIPE_LATENCY;

    // the pipeline never refuses a transfer
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every accepted temperature yields a result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after input transfer");

    // no result without an input transfer the fixed latency before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching input transfer");

endmodule

bind temperature_to_duration_interpolator tdi_checker u_tdi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ verif/temperature_to_duration_interpolator_tb.sv @@
// Self-checking testbench for the temperature to duration interpolator: directed and random runs.
`timescale 1ns / 100ps

module temperature_to_duration_interpolator_tb;
    import tdi_pkg::*;

    localparam int MAX_KNOTS    = DEFAULT_MAX_POINTS;
    localparam int LATENCY      = PIPE_LATENCY;
    localparam int RANDOM_ITEMS = 1000;
    // ~1100 items with their gaps and pipe drains fit well inside this limit
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_MAX   = 10;

    // Scoreboard: shadow copy of the breakpoint table, predicted durations in
    // transfer order, and the mismatch tally.
    class duration_scoreboard;
        logic [BP_W-1:0]    knots [MAX_KNOTS];
        logic [COUNT_W-1:0] point_count;
        logic [SECS_W-1:0]  expected_durations [$];
        int unsigned        mismatches;

        function new();
            point_count = '0;
            foreach (knots[i]) knots[i] = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BP_W-1:0] data);
            if (idx == REG_POINT_COUNT)
                point_count = data[COUNT_W-1:0];
            else
                knots[idx - REG_BREAKPOINT_0] = data;
        endfunction

        function longint knot_temp(int i);
            return longint'($signed(knots[i][BP_W-1:SECS_W]));
        endfunction

        function longint knot_secs(int i);
            return longint'(knots[i][SECS_W-1:0]);
        endfunction

        // Lower knot: highest index at or below t. Upper knot: lowest index at
        // or above t. Interpolate between them, truncating toward zero.
        function logic [SECS_W-1:0] predict_duration(logic signed [TEMP_W-1:0] t);
            int     n;
            int     i;
            int     lo;
            int     hi;
            bit     have_lo;
            bit     have_hi;
            longint span_t;
            longint acc;
            have_lo = 1'b0;
            have_hi = 1'b0;
            lo = 0;
            hi = 0;
            n = int'(point_count);
            if (n > MAX_KNOTS)
                n = MAX_KNOTS;
            for (i = 0; i < n; i++)
                if (knot_temp(i) <= longint'(t))
                begin
                    lo = i;
                    have_lo = 1'b1;
                end
            for (i = n; i > 0; i--)
                if (knot_temp(i - 1) >= longint'(t))
                begin
                    hi = i - 1;
                    have_hi = 1'b1;
                end
            if (have_lo && have_hi)
            begin
                span_t = knot_temp(hi) - knot_temp(lo);
                // exact hit or duplicate temperatures: no division
                if (span_t == 0)
                    acc = knot_secs(lo);
                else
                    acc = knot_secs(lo) + ((longint'(t) - knot_temp(lo)) *
                          (knot_secs(hi) - knot_secs(lo))) / span_t;
            end
            else if (have_hi)
                acc = knot_secs(hi);
            else if (have_lo)
                acc = knot_secs(lo);
            else
                acc = 0;
            if (acc < 0)
                acc = 0;
            if (acc > 65535)
                acc = 65535;
            return acc[SECS_W-1:0];
        endfunction

        // newest prediction at the front, oldest taken from the back
        function void note_temperature(logic signed [TEMP_W-1:0] t);
            expected_durations.push_front(predict_duration(t));
        endfunction

        function void check_duration(logic [SECS_W-1:0] actual);
            logic [SECS_W-1:0] expected;
            if (expected_durations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected duration %0d with nothing outstanding", actual);
            end
            else
            begin
                expected = expected_durations.pop_back();
                if (actual !== expected)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("duration mismatch: expected %0d got %0d", expected, actual);
                end
            end
        endfunction

        function int pending();
            return expected_durations.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [TEMP_W-1:0] temperature_in = '0;
    logic                     done;
    logic [SECS_W-1:0]        duration_seconds;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [BP_W-1:0]          cfg_data = '0;

    // table to be loaded by the next configuration pass
    logic [COUNT_W-1:0]       plan_count;
    logic [BP_W-1:0]          plan_knots [MAX_KNOTS];

    duration_scoreboard       board;
    int unsigned              cycles = 0;
    int unsigned              sent = 0;

    temperature_to_duration_interpolator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .temperature_in   (temperature_in),
        .done             (done),
        .duration_seconds (duration_seconds),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake or lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Monitor. All three channels are sampled at the edge, so values are the
    // pre-edge ones; register writes land before any transfer that follows.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_register(cfg_index, cfg_data);
            if (start && !busy)
                board.note_temperature(temperature_in);
            if (done)
                board.check_duration(duration_seconds);
        end
    end

    function automatic logic [BP_W-1:0] pack_knot(int temp, int secs);
        logic [31:0] t32;
        logic [31:0] s32;
        t32 = temp;
        s32 = secs;
        return {t32[TEMP_W-1:0], s32[SECS_W-1:0]};
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Random table: wide ordered, tight ordered cluster, or scrambled.
    task automatic make_random_plan();
        int kind;
        int base;
        int step;
        int temp;
        int secs;
        int r;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 65535 - 7 * 64) - 32768;
        step = $urandom_range(1, 64);
        temp = 0;
        plan_count = ($urandom_range(0, 15) == 0) ? '0 : COUNT_W'($urandom_range(1, MAX_KNOTS));
        for (int i = 0; i < MAX_KNOTS; i++)
        begin
            r = $urandom_range(0, 9);
            secs = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
            if (kind < 5)
                temp = -32768 + i * 9362 + $urandom_range(0, 9361);
            else if (kind < 8)
                temp = base + i * step;
            else if (i == 0 || $urandom_range(0, 3) != 0)
                temp = $urandom_range(0, 65535) - 32768;
            // else keep the previous temperature: duplicate knot
            plan_knots[i] = pack_knot(temp, secs);
        end
    endtask

    // Temperatures aimed at the knots in use, plus full-range noise.
    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int r;
        int k;
        int v;
        r = $urandom_range(0, 9);
        k = (plan_count != 0 && $urandom_range(0, 7) != 0) ?
            $urandom_range(0, plan_count - 1) : $urandom_range(0, MAX_KNOTS - 1);
        v = int'($signed(plan_knots[k][BP_W-1:SECS_W]));
        if (r < 3)
            ;
        else if (r < 7)
            v = v + $urandom_range(0, 16) - 8;
        else
            v = $urandom_range(0, 65535) - 32768;
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return TEMP_W'(v);
    endfunction

    // One pass over every register; the count word carries junk above bit 2.
    task automatic load_plan();
        logic [BP_W-1:0] junk;
        junk = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(REG_POINT_COUNT);
        cfg_data  <= {junk[BP_W-1:COUNT_W], plan_count};
        @(posedge clk);
        for (int i = 0; i < MAX_KNOTS; i++)
        begin
            cfg_index <= CFG_IDX_W'(REG_BREAKPOINT_0 + i);
            cfg_data  <= plan_knots[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Holds start until the transfer, then optionally idles. With no gap,
    // start stays high so the next call does not toggle it in the same step.
    task automatic send_temperature(input logic signed [TEMP_W-1:0] t, input int gap);
        start          <= 1'b1;
        temperature_in <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start, then wait until the last transfer has been noted and every result is in.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    initial
    begin
        board = new();
        foreach (plan_knots[i]) plan_knots[i] = '0;
        plan_count = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table after reset: always zero
        send_temperature(16'sh8000, 0);
        send_temperature(16'sh7FFF, 1);
        send_temperature(16'sh0000, 0);
        drain_results();

        // single knot: clamps on both sides and exact hit
        plan_count = 3'd1;
        plan_knots[0] = pack_knot(160, 300);
        for (int i = 1; i < MAX_KNOTS; i++) plan_knots[i] = $urandom();
        load_plan();
        send_temperature(16'sh8000, 0);
        send_temperature(16'sd159, 0);
        send_temperature(16'sd160, 2);
        send_temperature(16'sd161, 0);
        send_temperature(16'sh7FFF, 0);
        drain_results();

        // full table over the whole temperature range, extreme seconds
        plan_count = 3'd7;
        plan_knots[0] = pack_knot(-32768, 65535);
        plan_knots[1] = pack_knot(-1000, 0);
        plan_knots[2] = pack_knot(0, 1234);
        plan_knots[3] = pack_knot(100, 65535);
        plan_knots[4] = pack_knot(5000, 7);
        plan_knots[5] = pack_knot(20000, 40000);
        plan_knots[6] = pack_knot(32767, 0);
        load_plan();
        send_temperature(16'sh8000, 0);
        send_temperature(16'sh7FFF, 0);
        send_temperature(-16'sd1, 0);
        send_temperature(16'sd100, 1);
        send_temperature(16'sd50, 0);
        send_temperature(-16'sd20000, 0);
        send_temperature(16'sd2500, 3);
        send_temperature(16'sd32766, 0);
        send_temperature(-16'sd32767, 0);
        drain_results();

        // duplicate and out-of-order temperatures: zero span and odd search
        plan_count = 3'd6;
        plan_knots[0] = pack_knot(100, 1000);
        plan_knots[1] = pack_knot(200, 2000);
        plan_knots[2] = pack_knot(200, 3000);
        plan_knots[3] = pack_knot(300, 4000);
        plan_knots[4] = pack_knot(50, 65535);
        plan_knots[5] = pack_knot(32767, 0);
        load_plan();
        send_temperature(16'sd200, 0);
        send_temperature(16'sd150, 0);
        send_temperature(16'sd60, 0);
        send_temperature(16'sd250, 0);
        send_temperature(16'sh7FFF, 0);
        send_temperature(16'sh8000, 0);
        drain_results();

        // random tables, each followed by a burst of lookups
        while (sent < RANDOM_ITEMS)
        begin
            int  burst;
            bit  steady;
            make_random_plan();
            load_plan();
            burst  = $urandom_range(20, 80);
            steady = ($urandom_range(0, 3) == 0);
            repeat (burst)
            begin
                send_temperature(pick_temperature(), steady ? 0 : pick_gap());
                sent++;
            end
            drain_results();
        end

        // catch any stray strobe after the last expected result
        repeat (LATENCY + 4) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
